### hdl/lcf_pkg.sv
// Package for the length / CRC-8 frame checker: sizes, prefix phase and
// status codes, and the per-byte CRC and hex decode functions.
// No dependencies.
package lcf_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int PREFIX_WINDOW   = 10;
  // CRC snapshots after bytes 0 .. PREFIX_WINDOW+1 of a frame
  localparam int SNAP_N          = PREFIX_WINDOW + 2;
  localparam int SNAP_W          = $clog2(SNAP_N);
  localparam int BCNT_W          = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CHARS_W         = 4;
  localparam int LEN_W           = 16;

  localparam logic [7:0]       CRC_POLY  = 8'h8C;
  localparam logic [LEN_W-1:0] LEN_SAT   = 16'hFFFF;
  localparam logic [7:0]       CH_ZERO   = 8'h30;
  localparam logic [7:0]       CH_NINE   = 8'h39;
  localparam logic [7:0]       CH_UP_A   = 8'h41;
  localparam logic [7:0]       CH_UP_F   = 8'h46;
  localparam logic [7:0]       CH_PLUS   = 8'h2B;
  localparam logic [7:0]       CH_MINUS  = 8'h2D;
  localparam logic [7:0]       CH_POINT  = 8'h2E;

  typedef enum logic [1:0] {
    PH_INT  = 2'd0,
    PH_FRAC = 2'd1,
    PH_DOT  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_LEN = 2'd2
  } status_t;

  // reflected CRC-8, one byte, unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       lsb;
    c = crc;
    d = b;
    for (int j = 0; j < 8; j++) begin
      lsb = c[0] ^ d[0];
      c   = {1'b0, c[7:1]};
      if (lsb) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

  // {ok, nibble}; nibble is zero for a non-hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] r;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      r = {1'b1, ch[3:0]};
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      r = {1'b1, 4'(ch[3:0] + 4'd9)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

### hdl/length_crc8_frame_checker_top.sv
// Top level of the length / CRC-8 frame checker: stream in, one status word
// out per frame. Uses lcf_pkg.
//
// Takes one frame character per cycle on the in_ stream; in_tlast marks the
// last character. The frame opens with a decimal length (optional sign,
// integer digits, dropped fraction) and closes with two upper-case hex
// characters carrying a reflected CRC-8 (poly 0x8C, init 0) of the first
// length bytes. One result word appears per frame: the last character passes
// through an input register, then one pass of prefix parse, CRC update and
// final compare into the result register.
// Throughput is one character per clock; in_tready drops only while a finished
// result waits on out_tready and the registered character is itself a last
// character.
module length_crc8_frame_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [17:2] declared_length,
                                  // [25:18] computed_crc, [33:26] received_crc,
                                  // [39:34] zero
);

  localparam int BW = lcf_pkg::BCNT_W;
  localparam int LW = lcf_pkg::LEN_W;
  localparam int SW = lcf_pkg::SNAP_W;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance;

  // frame state
  logic [BW-1:0]                 bcnt_r, bcnt_nxt;
  logic                          too_long_r, too_long_nxt;
  logic [LW-1:0]                 plen_r, plen_nxt;
  lcf_pkg::phase_t               phase_r, phase_nxt;
  logic [lcf_pkg::CHARS_W-1:0]   chars_r, chars_nxt;
  logic                          neg_r, neg_nxt;
  logic [7:0]                    crc_r, crc_nxt;
  logic [15:0]                   tail_r, tail_nxt;
  logic [7:0]                    snap_r [lcf_pkg::SNAP_N];
  logic                          snap_we;
  logic [SW-1:0]                 snap_wa;

  // result register
  logic                          out_vld_r;
  lcf_pkg::status_t              status_r, status_nxt;
  logic [LW-1:0]                 dlen_r, dlen_nxt;
  logic [7:0]                    ccrc_r, ccrc_nxt;
  logic [7:0]                    rcrc_r, rcrc_nxt;

  // datapath temporaries
  logic              digit;
  logic              took;
  logic              p_zero;
  logic [19:0]       acc;
  logic [LW-1:0]     len_a;
  logic [LW-1:0]     len_f;
  logic [7:0]        crc_a;
  logic [7:0]        crc_b;
  logic [7:0]        crc_c;
  logic [BW-1:0]     total;
  logic [4:0]        hx_hi;
  logic [4:0]        hx_lo;

  assign advance   = in_vld_r && (!in_last_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // snapshot for a given byte count; count zero is the CRC seed
  function automatic logic [7:0] snap_rd(input logic [SW-1:0] idx,
                                         input logic [7:0] arr [lcf_pkg::SNAP_N]);
    logic [7:0] v;
    v = 8'd0;
    for (int i = 1; i < lcf_pkg::SNAP_N; i++) begin
      if (idx == SW'(i)) begin
        v = arr[i];
      end
    end
    return v;
  endfunction

  always_comb begin
    digit  = (in_byte_r >= lcf_pkg::CH_ZERO) && (in_byte_r <= lcf_pkg::CH_NINE);
    p_zero = (bcnt_r == '0);

    too_long_nxt = too_long_r || (bcnt_r >= BW'(lcf_pkg::MAX_FRAME_BYTES));
    plen_nxt  = plen_r;
    phase_nxt = phase_r;
    chars_nxt = chars_r;
    neg_nxt   = neg_r;
    took      = 1'b1;
    acc       = 20'({plen_r, 3'b000}) + 20'({plen_r, 1'b0}) + 20'(in_byte_r[3:0]);
    crc_a     = crc_r;

    // prefix parse
    if (phase_r != lcf_pkg::PH_DONE) begin
      if (phase_r == lcf_pkg::PH_DOT) begin
        if (digit) begin
          phase_nxt = lcf_pkg::PH_FRAC;
        end else begin
          took = 1'b0;
        end
      end else if (chars_r >= lcf_pkg::CHARS_W'(lcf_pkg::PREFIX_WINDOW)) begin
        took = 1'b0;
      end else if (p_zero && in_byte_r == lcf_pkg::CH_PLUS) begin
        took = 1'b1;
      end else if (p_zero && in_byte_r == lcf_pkg::CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (in_byte_r == lcf_pkg::CH_POINT) begin
        phase_nxt = lcf_pkg::PH_DOT;
      end else if (digit) begin
        if (phase_r == lcf_pkg::PH_INT) begin
          plen_nxt = (acc > 20'(lcf_pkg::LEN_SAT)) ? lcf_pkg::LEN_SAT : acc[LW-1:0];
        end
      end else begin
        took = 1'b0;
      end
      if (took) begin
        if (chars_r != '1) begin
          chars_nxt = chars_r + 1'b1;
        end
      end else begin
        phase_nxt = lcf_pkg::PH_DONE;
        // length shorter than bytes already hashed: roll back to its snapshot
        if (!neg_r && LW'(bcnt_r) > plen_r && plen_r < LW'(lcf_pkg::SNAP_N)) begin
          crc_a = snap_rd(plen_r[SW-1:0], snap_r);
        end else if (neg_r && !p_zero) begin
          crc_a = 8'd0;
        end
      end
    end

    len_a = neg_nxt ? '0 : plen_nxt;

    // CRC update and snapshot
    crc_b   = crc_a;
    snap_we = 1'b0;
    snap_wa = SW'(bcnt_r + 1'b1);
    if (!too_long_nxt) begin
      if (phase_nxt != lcf_pkg::PH_DONE || LW'(bcnt_r) < len_a) begin
        crc_b = lcf_pkg::crc8_byte(crc_a, in_byte_r);
      end
      snap_we = (bcnt_r < BW'(lcf_pkg::SNAP_N - 1));
    end

    tail_nxt = {tail_r[7:0], in_byte_r};
    bcnt_nxt = (bcnt_r < BW'(lcf_pkg::MAX_FRAME_BYTES)) ? bcnt_r + 1'b1 : bcnt_r;

    // frame end: prefix may still be open
    total = bcnt_nxt;
    len_f = len_a;
    crc_c = crc_b;
    if (phase_nxt != lcf_pkg::PH_DONE) begin
      if (len_f < LW'(total) && len_f < LW'(lcf_pkg::SNAP_N)) begin
        crc_c = snap_rd(len_f[SW-1:0], snap_r);
      end
    end

    hx_hi = lcf_pkg::hex_nibble(tail_nxt[15:8]);
    hx_lo = lcf_pkg::hex_nibble(tail_nxt[7:0]);

    dlen_nxt = len_f;
    ccrc_nxt = crc_c;
    rcrc_nxt = {hx_hi[3:0], hx_lo[3:0]};
    if (neg_nxt || too_long_nxt || total < BW'(2) || len_f != LW'(total - BW'(2))) begin
      status_nxt = lcf_pkg::ST_LEN;
    end else if (!hx_hi[4] || !hx_lo[4] || crc_c != rcrc_nxt) begin
      status_nxt = lcf_pkg::ST_CRC;
    end else begin
      status_nxt = lcf_pkg::ST_OK;
    end

    crc_nxt = crc_b;
  end

  // frame state; cleared after each last word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r     <= '0;
      too_long_r <= 1'b0;
      plen_r     <= '0;
      phase_r    <= lcf_pkg::PH_INT;
      chars_r    <= '0;
      neg_r      <= 1'b0;
      crc_r      <= '0;
      tail_r     <= '0;
    end else if (advance) begin
      if (in_last_r) begin
        bcnt_r     <= '0;
        too_long_r <= 1'b0;
        plen_r     <= '0;
        phase_r    <= lcf_pkg::PH_INT;
        chars_r    <= '0;
        neg_r      <= 1'b0;
        crc_r      <= '0;
        tail_r     <= '0;
      end else begin
        bcnt_r     <= bcnt_nxt;
        too_long_r <= too_long_nxt;
        plen_r     <= plen_nxt;
        phase_r    <= phase_nxt;
        chars_r    <= chars_nxt;
        neg_r      <= neg_nxt;
        crc_r      <= crc_nxt;
        tail_r     <= tail_nxt;
      end
    end
  end

  // snapshots are only read at counts already written in this frame
  always_ff @(posedge clk) begin
    if (advance && snap_we) begin
      snap_r[snap_wa] <= crc_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      status_r <= status_nxt;
      dlen_r   <= dlen_nxt;
      ccrc_r   <= ccrc_nxt;
      rcrc_r   <= rcrc_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, rcrc_r, ccrc_r, dlen_r, status_r};

endmodule

### tb/tb_length_crc8_frame_checker_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for length_crc8_frame_checker_top: directed frames, then random
// frames under several idle/stall mixes, checked against a behavioral frame checker.
// Depends on lcf_pkg and the top-level RTL.
module tb_length_crc8_frame_checker_top;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 300;
  localparam int N_DIR       = 19;
  // a tilde in the directed table stands for a NUL byte
  localparam logic [7:0] NUL_MARK = 8'h7E;

  typedef struct packed {
    logic [7:0]       rx_crc;
    logic [7:0]       calc_crc;
    logic [15:0]      decl_len;
    lcf_pkg::status_t status;
  } frame_res_t;

  localparam frame_res_t ZERO_LEN_ERR = '{rx_crc: 8'h00, calc_crc: 8'h00, decl_len: 16'd0,
                                          status: lcf_pkg::ST_LEN};

  typedef enum {TL_ASIS, TL_GOOD, TL_BAD} tail_t;
  typedef enum {MUT_EXTRA, MUT_DROP, MUT_MINUS, MUT_CUT, MUT_BIGLEN} mut_t;

  typedef struct {
    string body;
    tail_t tail;
    bit    typed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic        in_tlast = 1'b0;  // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [1:0] status, [17:2] declared_length,
                                 // [25:18] computed_crc, [33:26] received_crc

  length_crc8_frame_checker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  frame_res_t  frame_results_q[$];
  logic [7:0]  frm_bytes[$];
  dir_row_t    dir_tab [N_DIR];
  int          mismatches = 0;
  int          cyc_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  bit          hold_on = 1'b0;

  // frame checker state
  int unsigned      fc_count;
  bit               fc_overlong;
  int unsigned      fc_len;
  lcf_pkg::phase_t  fc_phase;
  int unsigned      fc_chars;
  bit               fc_minus;
  logic [7:0]       fc_crc;
  logic [15:0]      fc_tail;
  logic [7:0]       fc_snap [lcf_pkg::SNAP_N];

  function automatic bit is_dec(logic [7:0] c);
    return c >= lcf_pkg::CH_ZERO && c <= lcf_pkg::CH_NINE;
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return is_dec(c) || (c >= lcf_pkg::CH_UP_A && c <= lcf_pkg::CH_UP_F);
  endfunction

  function automatic logic [3:0] hex_nib(logic [7:0] c);
    if (is_dec(c)) begin
      return 4'(c - lcf_pkg::CH_ZERO);
    end else if (is_hex(c)) begin
      return 4'(c - lcf_pkg::CH_UP_A + 8'd10);
    end
    return 4'd0;
  endfunction

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      r = r[0] ? ((r >> 1) ^ lcf_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic int unsigned fc_eff_len();
    return fc_minus ? 0 : fc_len;
  endfunction

  // a length shorter than the prefix rolls the CRC back to its snapshot
  function automatic void fc_close_prefix(int unsigned held);
    int unsigned len;
    len = fc_eff_len();
    fc_phase = lcf_pkg::PH_DONE;
    if (len < held && len < lcf_pkg::SNAP_N) begin
      fc_crc = fc_snap[len];
    end
  endfunction

  function automatic void fc_clear();
    fc_count    = 0;
    fc_overlong = 1'b0;
    fc_len      = 0;
    fc_phase    = lcf_pkg::PH_INT;
    fc_chars    = 0;
    fc_minus    = 1'b0;
    fc_crc      = '0;
    fc_tail     = '0;
    for (int j = 0; j < lcf_pkg::SNAP_N; j++) begin
      fc_snap[j] = '0;
    end
  endfunction

  function automatic void frame_check_byte(input logic [7:0] c, input bit is_last,
                                           output frame_res_t res);
    int unsigned      pos;
    int unsigned      total;
    int unsigned      len;
    bit               took;
    bit               hex_ok;
    logic [7:0]       rx;
    lcf_pkg::status_t st;
    res = '0;
    if (fc_count >= lcf_pkg::MAX_FRAME_BYTES) begin
      fc_overlong = 1'b1;
    end
    pos = fc_count;
    if (fc_phase != lcf_pkg::PH_DONE) begin
      took = 1'b1;
      if (fc_phase == lcf_pkg::PH_DOT) begin
        if (is_dec(c)) begin
          fc_phase = lcf_pkg::PH_FRAC;
        end else begin
          took = 1'b0;
        end
      end else if (fc_chars >= lcf_pkg::PREFIX_WINDOW) begin
        took = 1'b0;
      end else if (pos == 0 && c == lcf_pkg::CH_PLUS) begin
        took = 1'b1;
      end else if (pos == 0 && c == lcf_pkg::CH_MINUS) begin
        fc_minus = 1'b1;
      end else if (c == lcf_pkg::CH_POINT) begin
        fc_phase = lcf_pkg::PH_DOT;
      end else if (is_dec(c)) begin
        if (fc_phase == lcf_pkg::PH_INT) begin
          fc_len = fc_len * 10 + (c - lcf_pkg::CH_ZERO);
          if (fc_len > lcf_pkg::LEN_SAT) begin
            fc_len = lcf_pkg::LEN_SAT;
          end
        end
      end else begin
        took = 1'b0;
      end
      if (took) begin
        if (fc_chars < 15) begin
          fc_chars++;
        end
      end else begin
        fc_close_prefix(pos);
      end
    end

    if (!fc_overlong) begin
      if (fc_phase != lcf_pkg::PH_DONE || pos < fc_eff_len()) begin
        fc_crc = crc8_step(fc_crc, c);
      end
      if (pos + 1 < lcf_pkg::SNAP_N) begin
        fc_snap[pos + 1] = fc_crc;
      end
    end
    fc_tail = {fc_tail[7:0], c};
    if (fc_count < lcf_pkg::MAX_FRAME_BYTES) begin
      fc_count++;
    end

    if (is_last) begin
      total = fc_count;
      if (fc_phase != lcf_pkg::PH_DONE) begin
        fc_close_prefix(total);
      end
      len    = fc_eff_len();
      hex_ok = is_hex(fc_tail[15:8]) && is_hex(fc_tail[7:0]);
      rx     = {hex_nib(fc_tail[15:8]), hex_nib(fc_tail[7:0])};
      if (fc_minus || fc_overlong || total < 2 || len != total - 2) begin
        st = lcf_pkg::ST_LEN;
      end else if (!hex_ok || fc_crc != rx) begin
        st = lcf_pkg::ST_CRC;
      end else begin
        st = lcf_pkg::ST_OK;
      end
      res.status   = st;
      res.decl_len = len[15:0];
      res.calc_crc = fc_crc;
      res.rx_crc   = rx;
      fc_clear();
    end
  endfunction

  function automatic logic [7:0] crc_over(int unsigned n);
    logic [7:0] crc;
    crc = '0;
    for (int k = 0; k < n && k < frm_bytes.size(); k++) begin
      crc = crc8_step(crc, frm_bytes[k]);
    end
    return crc;
  endfunction

  function automatic void push_hex(logic [7:0] v);
    logic [3:0] n;
    n = v[7:4];
    frm_bytes.push_back(n < 10 ? lcf_pkg::CH_ZERO + 8'(n) : lcf_pkg::CH_UP_A + 8'(n) - 8'd10);
    n = v[3:0];
    frm_bytes.push_back(n < 10 ? lcf_pkg::CH_ZERO + 8'(n) : lcf_pkg::CH_UP_A + 8'(n) - 8'd10);
  endfunction

  // length prefix, payload up to that length, then the CRC in hex (sometimes spoiled)
  task automatic build_wellformed(input int unsigned want_len);
    int unsigned decl;
    int          r;
    string       num;
    logic [7:0]  ch;
    logic [7:0]  crc;
    frm_bytes.delete();
    r = $urandom_range(99);
    if (want_len != 0) begin
      decl = want_len;
    end else if (r < 80) begin
      decl = $urandom_range(1, 24);
    end else if (r < 95) begin
      decl = $urandom_range(25, 120);
    end else begin
      decl = $urandom_range(121, 400);
    end
    if ($urandom_range(3) == 0) begin
      frm_bytes.push_back(lcf_pkg::CH_PLUS);
    end
    num = $sformatf("%0d", decl);
    for (int k = 0; k < num.len(); k++) begin
      frm_bytes.push_back(num[k]);
    end
    if ($urandom_range(4) == 0) begin
      frm_bytes.push_back(lcf_pkg::CH_POINT);
      repeat ($urandom_range(1, 3)) begin
        frm_bytes.push_back(lcf_pkg::CH_ZERO + 8'($urandom_range(9)));
      end
    end
    if (frm_bytes.size() < decl) begin
      // first payload byte has to end the prefix
      do begin
        ch = 8'($urandom_range(255));
      end while (is_dec(ch) || ch == lcf_pkg::CH_POINT);
      frm_bytes.push_back(ch);
      while (frm_bytes.size() < decl) begin
        frm_bytes.push_back(8'($urandom_range(255)));
      end
    end
    crc = crc_over(decl);
    r = $urandom_range(99);
    if (want_len == 0 && r >= 85 && r < 93) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_hex(crc);
    if (want_len == 0 && r >= 93) begin
      do begin
        ch = 8'($urandom_range(255));
      end while (is_hex(ch));
      frm_bytes[frm_bytes.size() - 1 - $urandom_range(1)] = ch;
    end
  endtask

  task automatic send_frame(input bit typed, input frame_res_t want);
    frame_res_t pred;
    bit         is_last;
    for (int k = 0; k < frm_bytes.size(); k++) begin
      is_last = (k == frm_bytes.size() - 1);
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = frm_bytes[k];
      in_tlast  = is_last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      frame_check_byte(frm_bytes[k], is_last, pred);
      if (is_last) begin
        frame_results_q.push_back(typed ? want : pred);
      end
      @(negedge clk);
    end
  endtask

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  always @(negedge clk) begin
    out_tready = !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the checker backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  always @(posedge clk) begin
    frame_res_t got;
    frame_res_t want;
    got = frame_res_t'(out_tdata[33:0]);
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word st=%0d len=%0d crc=%02h rx=%02h",
                                got.status, got.decl_len, got.calc_crc, got.rx_crc));
      end else begin
        want = frame_results_q.pop_front();
        if (got.status !== want.status || got.decl_len !== want.decl_len ||
            got.calc_crc !== want.calc_crc || got.rx_crc !== want.rx_crc) begin
          note_mismatch($sformatf(
            "want st=%0d len=%0d crc=%02h rx=%02h, got st=%0d len=%0d crc=%02h rx=%02h",
            want.status, want.decl_len, want.calc_crc, want.rx_crc,
            got.status, got.decl_len, got.calc_crc, got.rx_crc));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int    sent;
    int    r;
    int    n;
    mut_t  mut;
    string noise_chars;
    int    idle_tab [4];
    int    stall_tab [4];
    noise_chars = "0123456789+-.AFaf";
    idle_tab    = '{0, 71, 0, 13};
    stall_tab   = '{0, 0, 71, 13};
    dir_tab = '{
      '{"Z",              TL_ASIS, 1'b1},
      '{"+",              TL_ASIS, 1'b1},
      '{"-",              TL_ASIS, 1'b1},
      '{"000",            TL_ASIS, 1'b1},
      '{"-3xx00",         TL_ASIS, 1'b1},
      '{"4abc",           TL_GOOD, 1'b0},
      '{"+5abc",          TL_GOOD, 1'b0},
      '{"7.25abc",        TL_GOOD, 1'b0},
      '{"8.1.5xyz",       TL_GOOD, 1'b0},
      '{"5.xyz",          TL_GOOD, 1'b0},
      '{"6a~\377bc",      TL_GOOD, 1'b0},
      '{"3-x",            TL_GOOD, 1'b0},
      '{"1",              TL_GOOD, 1'b0},
      '{"4abc",           TL_BAD,  1'b0},
      '{"4abczz",         TL_ASIS, 1'b0},
      '{"50ab12",         TL_ASIS, 1'b0},
      '{"00000000012abc", TL_ASIS, 1'b0},
      '{"99999999ZZ",     TL_ASIS, 1'b0},
      '{"2.AB",           TL_ASIS, 1'b0}
    };
    fc_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      frm_bytes.delete();
      for (int k = 0; k < dir_tab[i].body.len(); k++) begin
        frm_bytes.push_back(dir_tab[i].body[k] == NUL_MARK ? 8'h00 : dir_tab[i].body[k]);
      end
      if (dir_tab[i].tail != TL_ASIS) begin
        push_hex(crc_over(frm_bytes.size()) ^ (dir_tab[i].tail == TL_BAD ? 8'h5A : 8'h00));
      end
      send_frame(dir_tab[i].typed, ZERO_LEN_ERR);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) begin
        hold_go = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 65) begin
          build_wellformed(0);
        end else if (r < 85) begin
          build_wellformed(0);
          mut = mut_t'($urandom_range(4));
          case (mut)
            MUT_EXTRA: begin
              frm_bytes.insert(frm_bytes.size() - 2, 8'($urandom_range(255)));
            end
            MUT_DROP: begin
              frm_bytes.delete(frm_bytes.size() - 3);
            end
            MUT_MINUS: begin
              frm_bytes.push_front(lcf_pkg::CH_MINUS);
            end
            MUT_CUT: begin
              n = $urandom_range(1, frm_bytes.size() - 1);
              while (frm_bytes.size() > n) void'(frm_bytes.pop_back());
            end
            default: begin
              repeat ($urandom_range(1, 6)) begin
                frm_bytes.push_front(lcf_pkg::CH_ZERO + 8'($urandom_range(9)));
              end
            end
          endcase
        end else begin
          frm_bytes.delete();
          n = $urandom_range(1, 20);
          repeat (n) begin
            if ($urandom_range(1) == 0) begin
              frm_bytes.push_back(noise_chars[$urandom_range(noise_chars.len() - 1)]);
            end else begin
              frm_bytes.push_back(8'($urandom_range(255)));
            end
          end
        end
        sent += frm_bytes.size();
        send_frame(1'b0, '0);
      end
    end
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;

    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/lcf_pkg.sv
hdl/length_crc8_frame_checker_top.sv
tb/tb_length_crc8_frame_checker_top.sv
